>>> rtl/roundtrip_window_average_stats_assert.svh
`ifndef ROUNDTRIP_WINDOW_AVERAGE_STATS_ASSERT_SVH
`define ROUNDTRIP_WINDOW_AVERAGE_STATS_ASSERT_SVH

// Both macros sample on the rising edge of clock and are off while reset is high.

`define RWAS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

`define RWAS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rwas_pkg.sv
package rwas_pkg;

   localparam int WINDOW_DEFAULT = 8;
   localparam int SAMPLE_W       = 16;
   localparam int ALU_W          = SAMPLE_W + 7;

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   typedef struct packed {
      logic                action;
      logic [SAMPLE_W-1:0] sample_ms;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] average_ms;
      logic [SAMPLE_W-1:0] max_ms;
      logic [SAMPLE_W-1:0] min_ms;
      logic                stats_valid;
   } rsp_type;

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] op_a;
      logic [ALU_W-1:0] op_b;
   } alu_in_type;

   typedef struct packed {
      logic [ALU_W-1:0] result;
      logic             borrow;
   } alu_out_type;

endpackage

>>> rtl/rwas_alu.sv
module rwas_alu
   import rwas_pkg::*;
(
   input  alu_in_type  alu_in,
   output alu_out_type alu_out
);

   logic [ALU_W-1:0] op_b_eff;
   logic [ALU_W:0]   total;

   assign op_b_eff = alu_in.sub ? ~alu_in.op_b : alu_in.op_b;
   assign total    = {1'b0, alu_in.op_a} + {1'b0, op_b_eff} + (ALU_W + 1)'(alu_in.sub);

   assign alu_out.result = total[ALU_W-1:0];
   assign alu_out.borrow = alu_in.sub & ~total[ALU_W];

endmodule

>>> rtl/roundtrip_window_average_stats.sv
// Channel    Ports                               Direction  Payload
// request    req_valid, req_ready, req_data      in         req_type
// response   rsp_valid, rsp_ready, rsp_data      out        rsp_type
//
// An add request, once accepted, makes one pass over the window, then takes one
// quotient bit a cycle, all on one shared adder/subtractor. A clear request goes
// straight to the response step. Reset zeroes the window, the minimum and the
// maximum but not the average; there is no clearing pass.
// A finished response waits in the output register while the next request is
// accepted; the block stalls only at its last step if that register is still full.
`include "roundtrip_window_average_stats_assert.svh"

module roundtrip_window_average_stats
   import rwas_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int STEP_W = $clog2((SUM_W > WINDOW) ? SUM_W : WINDOW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_MIN,
      ST_MAX,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [SAMPLE_W-1:0] win_ff [WINDOW];
   logic [SAMPLE_W-1:0] win_in [WINDOW];
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic                present_ff, present_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W:0]      rem_shift;
   alu_in_type          alu_in;
   alu_out_type         alu_out;

   rwas_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rem_shift = {rem_ff, acc_ff[SUM_W-1]};

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      win_in       = win_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      present_in   = present_ff;
      avg_in       = avg_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      alu_in       = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action == ACT_CLEAR) begin
                  for (int i = 0; i < WINDOW; i++) begin
                     win_in[i] = '0;
                  end
                  max_in     = '0;
                  min_in     = '0;
                  present_in = 1'b0;
                  avg_in     = '0;
                  state_in   = ST_DONE;
               end else begin
                  for (int i = 0; i < WINDOW - 1; i++) begin
                     win_in[i] = win_ff[i+1];
                  end
                  win_in[WINDOW-1] = req_data.sample_ms;
                  acc_in   = '0;
                  cnt_in   = '0;
                  step_in  = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            alu_in.op_a = ALU_W'(acc_ff);
            alu_in.op_b = ALU_W'(win_ff[0]);
            // The new sample reaches the head on the last pass and always counts.
            if (win_ff[0] != '0 || step_ff == STEP_W'(WINDOW - 1)) begin
               acc_in = alu_out.result[SUM_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
            end
            for (int i = 0; i < WINDOW - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WINDOW-1] = win_ff[0];
            if (step_ff == STEP_W'(WINDOW - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DIV: begin
            alu_in.sub  = 1'b1;
            alu_in.op_a = ALU_W'(rem_shift);
            alu_in.op_b = ALU_W'(cnt_ff);
            if (alu_out.borrow) begin
               rem_in = rem_shift[CNT_W-1:0];
               acc_in = {acc_ff[SUM_W-2:0], 1'b0};
            end else begin
               rem_in = alu_out.result[CNT_W-1:0];
               acc_in = {acc_ff[SUM_W-2:0], 1'b1};
            end
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_MIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_MIN: begin
            avg_in      = acc_ff[SAMPLE_W-1:0];
            alu_in.sub  = 1'b1;
            alu_in.op_a = ALU_W'(acc_ff[SAMPLE_W-1:0]);
            alu_in.op_b = ALU_W'(min_ff);
            if (!present_ff) begin
               max_in     = win_ff[WINDOW-1];
               min_in     = acc_ff[SAMPLE_W-1:0];
               present_in = 1'b1;
            end else if (alu_out.borrow) begin
               min_in = acc_ff[SAMPLE_W-1:0];
            end
            state_in = ST_MAX;
         end
         ST_MAX: begin
            alu_in.sub  = 1'b1;
            alu_in.op_a = ALU_W'(max_ff);
            alu_in.op_b = ALU_W'(avg_ff);
            if (alu_out.borrow) begin
               max_in = avg_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.average_ms  = avg_ff;
               rsp_in.max_ms      = max_ff;
               rsp_in.min_ms      = min_ff;
               rsp_in.stats_valid = present_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         max_ff       <= '0;
         min_ff       <= '0;
         present_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
         win_ff       <= win_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         present_ff   <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff  <= avg_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
   end

   `RWAS_ASSERT(a_min_le_max, !present_ff || (min_ff <= max_ff), "minimum above maximum")
   `RWAS_ASSERT(a_empty_zero, present_ff || (max_ff == '0 && min_ff == '0),
                "statistics not zero while empty")
   `RWAS_ASSERT(a_div_rem, state_ff != ST_DIV || (cnt_ff != '0 && rem_ff < cnt_ff),
                "division remainder out of range")
   `RWAS_ASSERT(a_rsp_clear_zero,
                !rsp_valid_ff || rsp_ff.stats_valid ||
                (rsp_ff.average_ms == '0 && rsp_ff.max_ms == '0 && rsp_ff.min_ms == '0),
                "clear response carries nonzero statistics")
   `RWAS_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_ff != ST_IDLE,
                     "request accepted without leaving idle")

endmodule
